/* src/lav_pkg.sv */
package lav_pkg;

  // Fraction bits of the Q16.16 format.
  localparam int FRAC_BITS = 16;
  // A normalized magnitude has its largest component in [2^29, 2^30).
  localparam int NORM_BITS = 30;
  // Sum of three squares of normalized magnitudes, below 2^62.
  localparam int SUM_BITS  = 2 * NORM_BITS + 2;
  // Integer square root of that sum.
  localparam int SQRT_BITS = 31;
  // Unit component magnitude, at most 1.0.
  localparam int QUO_BITS  = FRAC_BITS + 1;
  // Dividend of the unit division: magnitude times 1.0 plus half the root.
  localparam int NUM_BITS  = NORM_BITS + FRAC_BITS + 1;

  localparam logic [31:0] FX_ONE   = 32'h0001_0000;
  localparam logic [1:0]  LAST_COL = 2'd3;

  // Signed Q2.16 unit vector component, range -1.0 to 1.0.
  typedef logic signed [QUO_BITS:0] unit_t;

endpackage

/* src/lav_norm.sv */
module lav_norm #(
  parameter int W      = 33,
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [2:0][W-1:0]          vin,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_valid,
  output logic                       out_zero,
  output lav_pkg::unit_t [2:0]       unit,
  output logic [SIDE_W-1:0]          side_out
);
  import lav_pkg::*;

  localparam int LZW = $clog2(W);

  typedef struct packed {
    logic [2:0]        neg;
    logic              zero;
    logic [SIDE_W-1:0] side;
  } tag_t;

  function automatic logic [LZW-1:0] lzc(input logic [W-1:0] x);
    logic [LZW-1:0] n;
    n = '0;
    for (int k = 0; k < W; k++) begin
      if (x[k]) n = LZW'(W - 1 - k);
    end
    return n;
  endfunction

  // Magnitudes.
  logic              v1;
  logic [2:0][W-1:0] a1;
  logic [2:0]        neg1;
  logic [SIDE_W-1:0] side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i]   <= vin[i][W-1] ? (~vin[i] + W'(1)) : vin[i];
        neg1[i] <= vin[i][W-1];
      end
      side1 <= side_in;
    end
  end

  // Largest magnitude.
  logic              v2;
  logic [W-1:0]      m2;
  logic [2:0][W-1:0] a2;
  logic [2:0]        neg2;
  logic [SIDE_W-1:0] side2;
  logic [W-1:0]      mx;

  always_comb begin
    mx = a1[0];
    if (a1[1] > mx) mx = a1[1];
    if (a1[2] > mx) mx = a1[2];
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2    <= mx;
      a2    <= a1;
      neg2  <= neg1;
      side2 <= side1;
    end
  end

  // Leading zero count of the largest magnitude.
  logic              v3;
  logic [LZW-1:0]    lz3;
  logic [2:0][W-1:0] a3;
  tag_t              tag3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lz3       <= lzc(m2);
      a3        <= a2;
      tag3.neg  <= neg2;
      tag3.zero <= (m2 == '0);
      tag3.side <= side2;
    end
  end

  // Left-align so that the top NORM_BITS bits keep the largest in [2^29, 2^30).
  logic                      v4;
  logic [2:0][NORM_BITS-1:0] n4;
  tag_t                      tag4;
  logic [2:0][W-1:0]         al;

  always_comb begin
    for (int i = 0; i < 3; i++) al[i] = a3[i] << lz3;
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) n4[i] <= al[i][W-1 -: NORM_BITS];
      tag4 <= tag3;
    end
  end

  // Squares.
  logic                        v5;
  logic [2:0][2*NORM_BITS-1:0] sq5;
  logic [2:0][NORM_BITS-1:0]   n5;
  tag_t                        tag5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq5[i] <= n4[i] * n4[i];
      n5   <= n4;
      tag5 <= tag4;
    end
  end

  // Square root, one result bit per stage. Index 0 holds the sum of squares.
  logic                      sq_v   [0:SQRT_BITS];
  logic [SUM_BITS+1:0]       sq_rem [0:SQRT_BITS];
  logic [SQRT_BITS-1:0]      sq_res [0:SQRT_BITS];
  logic [2:0][NORM_BITS-1:0] sq_n   [0:SQRT_BITS];
  tag_t                      sq_tag [0:SQRT_BITS];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0] <= (SUM_BITS+2)'(sq5[0]) + (SUM_BITS+2)'(sq5[1]) + (SUM_BITS+2)'(sq5[2]);
      sq_res[0] <= '0;
      sq_n[0]   <= n5;
      sq_tag[0] <= tag5;
    end
  end

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    localparam int K = SQRT_BITS - 1 - j;
    logic [SUM_BITS+1:0] trial;

    assign trial = ((SUM_BITS+2)'(sq_res[j]) << (K + 1))
                 + ((SUM_BITS+2)'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (en) sq_v[j+1] <= sq_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_n[j+1]   <= sq_n[j];
        sq_tag[j+1] <= sq_tag[j];
        if (sq_rem[j] >= trial) begin
          sq_rem[j+1] <= sq_rem[j] - trial;
          sq_res[j+1] <= sq_res[j] | (SQRT_BITS'(1) << K);
        end else begin
          sq_rem[j+1] <= sq_rem[j];
          sq_res[j+1] <= sq_res[j];
        end
      end
    end
  end

  // Unit division, one quotient bit per stage, three lanes.
  // Index 0 holds magnitude times 1.0 plus half the root, rounding the quotient.
  logic                     dv_v   [0:QUO_BITS];
  logic [2:0][NUM_BITS:0]   dv_rem [0:QUO_BITS];
  logic [2:0][QUO_BITS-1:0] dv_q   [0:QUO_BITS];
  logic [SQRT_BITS-1:0]     dv_r   [0:QUO_BITS];
  tag_t                     dv_tag [0:QUO_BITS];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[SQRT_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NUM_BITS+1)'({sq_n[SQRT_BITS][i], {FRAC_BITS{1'b0}}})
                      + (NUM_BITS+1)'(sq_res[SQRT_BITS] >> 1);
      end
      dv_q[0]   <= '0;
      dv_r[0]   <= sq_res[SQRT_BITS];
      dv_tag[0] <= sq_tag[SQRT_BITS];
    end
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int K = QUO_BITS - 1 - j;
    logic [NUM_BITS:0] dsh;

    assign dsh = (NUM_BITS+1)'(dv_r[j]) << K;

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j+1]   <= dv_r[j];
        dv_tag[j+1] <= dv_tag[j];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= dsh) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - dsh;
            dv_q[j+1][i]   <= dv_q[j][i] | (QUO_BITS'(1) << K);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
      end
    end
  end

  // Restore the signs.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_v[QUO_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_tag[QUO_BITS].neg[i]) unit[i] <= unit_t'(-$signed({1'b0, dv_q[QUO_BITS][i]}));
        else unit[i] <= unit_t'({1'b0, dv_q[QUO_BITS][i]});
      end
      out_zero <= dv_tag[QUO_BITS].zero;
      side_out <= dv_tag[QUO_BITS].side;
    end
  end

endmodule

/* src/look_at_view_matrix.sv */
// Right-handed look-at view matrix in signed Q16.16. Each input item (eye,
// target, up) yields four result items, the columns of the column-major view
// matrix in order 0 to 3, the last one flagged; degenerate marks all four when
// eye equals target or up is zero or parallel to the forward vector, and the
// matrix is then identity. From an accepted item to column 0 the path runs
// through two normalizers of 56 stages each (31 stages of bit-serial square
// root and 17 stages of unit division), plus cross product, dot product,
// rounding and saturation stages. A new item can be accepted every cycle while
// the output buffer is free; the buffer sends one column per cycle while
// out_stall is low, and stalls the input until its last column is sent.
module look_at_view_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] upvec_x,
  input  logic signed [31:0] upvec_y,
  input  logic signed [31:0] upvec_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         column_index,
  output logic signed [31:0] row0,
  output logic signed [31:0] row1,
  output logic signed [31:0] row2,
  output logic signed [31:0] row3,
  output logic               last_column,
  output logic               degenerate
);
  import lav_pkg::*;

  localparam logic [55:0] ROUND_HALF = 56'h8000;
  localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN    = 32'h8000_0000;

  typedef struct packed {
    logic             degen;
    unit_t [2:0]      s;
    unit_t [2:0]      f;
    logic [2:0][31:0] eye;
    logic [2:0][35:0] pa;
    logic [2:0][35:0] pb;
    logic [2:0][49:0] ps;
    logic [2:0][49:0] pf;
    logic [2:0][36:0] ur;
    logic [51:0]      ts;
    logic [51:0]      tf;
    logic [2:0][18:0] u;
    logic [36:0]      tsr;
    logic [36:0]      tfr;
    logic [31:0]      ts32;
    logic [31:0]      tf32;
    logic [2:0][50:0] pu;
    logic [52:0]      tu;
    logic [37:0]      tur;
    logic [31:0]      tu32;
  } tail_t;

  // Q24.32 to Q26.16 with the magnitude rounded half away from zero.
  // With neg set the value is negated first.
  function automatic logic [41:0] rnd(input logic signed [55:0] x, input logic neg);
    logic [55:0] mag;
    logic [41:0] q;
    logic        flip;
    mag  = x[55] ? 56'(-x) : 56'(x);
    q    = 42'((mag + ROUND_HALF) >> FRAC_BITS);
    flip = neg ? (!x[55] && (x != '0)) : x[55];
    return flip ? (~q + 42'd1) : q;
  endfunction

  function automatic logic [31:0] sat(input logic [41:0] x);
    if (!x[41] && (|x[40:31])) return SAT_MAX;
    else if (x[41] && !(&x[40:31])) return SAT_MIN;
    else return x[31:0];
  endfunction

  logic adv;
  logic out_acc;
  logic mat_v;
  logic [1:0] cnt;

  assign out_acc  = out_valid && !out_stall;
  assign adv      = !mat_v || (out_acc && (cnt == LAST_COL));
  assign in_stall = !adv;

  // Input stage: forward difference.
  logic             t1_v;
  logic [2:0][32:0] t1_d;
  logic [2:0][31:0] t1_eye;
  logic [2:0][31:0] t1_up;

  always_ff @(posedge clk) begin
    if (rst) t1_v <= 1'b0;
    else if (adv) t1_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_d[0]   <= 33'($signed(target_x)) - 33'($signed(eye_x));
      t1_d[1]   <= 33'($signed(target_y)) - 33'($signed(eye_y));
      t1_d[2]   <= 33'($signed(target_z)) - 33'($signed(eye_z));
      t1_eye    <= {eye_z, eye_y, eye_x};
      t1_up     <= {upvec_z, upvec_y, upvec_x};
    end
  end

  // Forward vector.
  logic             n1_v;
  logic             n1_zero;
  unit_t [2:0]      n1_f;
  logic [191:0]     n1_side;
  logic [2:0][31:0] n1_eye;
  logic [2:0][31:0] n1_up;

  lav_norm #(.W(33), .SIDE_W(192)) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (t1_v),
    .vin      (t1_d),
    .side_in  ({t1_eye, t1_up}),
    .out_valid(n1_v),
    .out_zero (n1_zero),
    .unit     (n1_f),
    .side_out (n1_side)
  );

  assign n1_eye = n1_side[191:96];
  assign n1_up  = n1_side[95:0];

  // Side vector before normalization: forward cross up, exact.
  logic             t2_v;
  logic [5:0][49:0] t2_p;
  logic [2:0][31:0] t2_eye;
  unit_t [2:0]      t2_f;
  logic             t2_zero;

  always_ff @(posedge clk) begin
    if (rst) t2_v <= 1'b0;
    else if (adv) t2_v <= n1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_p[0] <= $signed(n1_f[1]) * $signed(n1_up[2]);
      t2_p[1] <= $signed(n1_f[2]) * $signed(n1_up[1]);
      t2_p[2] <= $signed(n1_f[2]) * $signed(n1_up[0]);
      t2_p[3] <= $signed(n1_f[0]) * $signed(n1_up[2]);
      t2_p[4] <= $signed(n1_f[0]) * $signed(n1_up[1]);
      t2_p[5] <= $signed(n1_f[1]) * $signed(n1_up[0]);
      t2_eye  <= n1_eye;
      t2_f    <= n1_f;
      t2_zero <= n1_zero;
    end
  end

  logic             t3_v;
  logic [2:0][50:0] t3_sr;
  logic [2:0][31:0] t3_eye;
  unit_t [2:0]      t3_f;
  logic             t3_zero;

  always_ff @(posedge clk) begin
    if (rst) t3_v <= 1'b0;
    else if (adv) t3_v <= t2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_sr[0] <= 51'($signed(t2_p[0])) - 51'($signed(t2_p[1]));
      t3_sr[1] <= 51'($signed(t2_p[2])) - 51'($signed(t2_p[3]));
      t3_sr[2] <= 51'($signed(t2_p[4])) - 51'($signed(t2_p[5]));
      t3_eye   <= t2_eye;
      t3_f     <= t2_f;
      t3_zero  <= t2_zero;
    end
  end

  // Side vector.
  logic             n2_v;
  logic             n2_zero;
  unit_t [2:0]      n2_s;
  logic [150:0]     n2_side;

  lav_norm #(.W(51), .SIDE_W(151)) u_norm_side (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (t3_v),
    .vin      (t3_sr),
    .side_in  ({t3_eye, t3_f, t3_zero}),
    .out_valid(n2_v),
    .out_zero (n2_zero),
    .unit     (n2_s),
    .side_out (n2_side)
  );

  // Tail: true up vector, translation terms, rounding and saturation.
  logic  tv4, tv5, tv6, tv7, tv8, tv9, tv10;
  tail_t tl4, tl5, tl6, tl7, tl8, tl9, tl10;
  tail_t tn4, tn5, tn6, tn7, tn8, tn9, tn10;

  always_comb begin
    tn4       = '0;
    tn4.degen = n2_zero | n2_side[0];
    tn4.s     = n2_s;
    tn4.f     = n2_side[54:1];
    tn4.eye   = n2_side[150:55];
    tn4.pa[0] = $signed(tn4.s[1]) * $signed(tn4.f[2]);
    tn4.pb[0] = $signed(tn4.s[2]) * $signed(tn4.f[1]);
    tn4.pa[1] = $signed(tn4.s[2]) * $signed(tn4.f[0]);
    tn4.pb[1] = $signed(tn4.s[0]) * $signed(tn4.f[2]);
    tn4.pa[2] = $signed(tn4.s[0]) * $signed(tn4.f[1]);
    tn4.pb[2] = $signed(tn4.s[1]) * $signed(tn4.f[0]);
    for (int i = 0; i < 3; i++) begin
      tn4.ps[i] = $signed(tn4.s[i]) * $signed(tn4.eye[i]);
      tn4.pf[i] = $signed(tn4.f[i]) * $signed(tn4.eye[i]);
    end
  end

  always_comb begin
    tn5 = tl4;
    for (int i = 0; i < 3; i++) begin
      tn5.ur[i] = 37'($signed(tl4.pa[i])) - 37'($signed(tl4.pb[i]));
    end
    tn5.ts = 52'($signed(tl4.ps[0])) + 52'($signed(tl4.ps[1])) + 52'($signed(tl4.ps[2]));
    tn5.tf = 52'($signed(tl4.pf[0])) + 52'($signed(tl4.pf[1])) + 52'($signed(tl4.pf[2]));
  end

  always_comb begin
    tn6 = tl5;
    for (int i = 0; i < 3; i++) begin
      tn6.u[i] = 19'(rnd(56'($signed(tl5.ur[i])), 1'b0));
    end
    tn6.tsr = 37'(rnd(56'($signed(tl5.ts)), 1'b1));
    tn6.tfr = 37'(rnd(56'($signed(tl5.tf)), 1'b0));
  end

  always_comb begin
    tn7 = tl6;
    for (int i = 0; i < 3; i++) begin
      tn7.pu[i] = $signed(tl6.u[i]) * $signed(tl6.eye[i]);
    end
    tn7.ts32 = sat(42'($signed(tl6.tsr)));
    tn7.tf32 = sat(42'($signed(tl6.tfr)));
  end

  always_comb begin
    tn8    = tl7;
    tn8.tu = 53'($signed(tl7.pu[0])) + 53'($signed(tl7.pu[1])) + 53'($signed(tl7.pu[2]));
  end

  always_comb begin
    tn9     = tl8;
    tn9.tur = 38'(rnd(56'($signed(tl8.tu)), 1'b1));
  end

  always_comb begin
    tn10      = tl9;
    tn10.tu32 = sat(42'($signed(tl9.tur)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv4  <= 1'b0;
      tv5  <= 1'b0;
      tv6  <= 1'b0;
      tv7  <= 1'b0;
      tv8  <= 1'b0;
      tv9  <= 1'b0;
      tv10 <= 1'b0;
    end else if (adv) begin
      tv4  <= n2_v;
      tv5  <= tv4;
      tv6  <= tv5;
      tv7  <= tv6;
      tv8  <= tv7;
      tv9  <= tv8;
      tv10 <= tv9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tl4  <= tn4;
      tl5  <= tn5;
      tl6  <= tn6;
      tl7  <= tn7;
      tl8  <= tn8;
      tl9  <= tn9;
      tl10 <= tn10;
    end
  end

  // Output buffer: one finished matrix, sent one column per cycle while out_stall is low.
  logic [3:0][3:0][31:0] mat;
  logic [3:0][3:0][31:0] mat_next;
  logic                  mat_degen;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mat_next[c][r] = (c == r) ? FX_ONE : '0;
      end
    end
    if (!tl10.degen) begin
      for (int c = 0; c < 3; c++) begin
        mat_next[c][0] = 32'($signed(tl10.s[c]));
        mat_next[c][1] = 32'($signed(tl10.u[c]));
        mat_next[c][2] = 32'(-$signed(tl10.f[c]));
        mat_next[c][3] = '0;
      end
      mat_next[3][0] = tl10.ts32;
      mat_next[3][1] = tl10.tu32;
      mat_next[3][2] = tl10.tf32;
      mat_next[3][3] = FX_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_v <= 1'b0;
      cnt   <= '0;
    end else if (adv) begin
      mat_v <= tv10;
      cnt   <= '0;
    end else if (out_acc) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat       <= mat_next;
      mat_degen <= tl10.degen;
    end
  end

  assign out_valid    = mat_v;
  assign column_index = cnt;
  assign row0         = mat[cnt][0];
  assign row1         = mat[cnt][1];
  assign row2         = mat[cnt][2];
  assign row3         = mat[cnt][3];
  assign last_column  = (cnt == LAST_COL);
  assign degenerate   = mat_degen;

  // Columns of one matrix come out in order without a gap in the buffer.
  a_col_order: assert property (@(posedge clk) disable iff (rst)
    out_acc && (column_index != LAST_COL) |=>
      out_valid && (column_index == $past(column_index) + 2'd1))
    else $error("column sequence broken");

  // The degenerate flag is the same on every column of a matrix.
  a_degen_hold: assert property (@(posedge clk) disable iff (rst)
    out_acc && (column_index != LAST_COL) |=> $stable(degenerate))
    else $error("degenerate flag changed within a matrix");

  // The last column of a degenerate matrix is that of the identity.
  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate && last_column |->
      (row0 == '0) && (row1 == '0) && (row2 == '0) && (row3 == FX_ONE))
    else $error("degenerate matrix is not identity");

  // The pipeline never stalls its input while the output buffer is empty.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output buffer");

endmodule
